@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/dctq_pkg.sv @@
// Types, constants and helpers for the deadline callout timer queue.
`timescale 1ns / 1ps
package dctq_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int BUCKETS    = 8;
    localparam int FIRE_LIMIT = 63;
    localparam int FIRE_W     = 6;

    localparam logic [15:0] MIN_RESET = 16'd50;
    localparam logic [31:0] MAX_RESET = 32'd50000000;

    localparam logic [2:0] OP_SCHED  = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_TIME   = 3'd2;
    localparam logic [2:0] OP_HIST   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_DELAY = 2'd1;
    localparam logic [1:0] KIND_HIST  = 2'd2;
    localparam logic [1:0] KIND_SLOT  = 2'd3;

    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;

    localparam logic [9:0] LAT_EDGE [BUCKETS] =
        '{10'd1, 10'd2, 10'd5, 10'd10, 10'd20, 10'd50, 10'd100, 10'd1000};

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [3:0]  bucket;
        logic [63:0] time_value;
        logic        relative;
        logic [31:0] period;
        logic [63:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fired_slot;
        logic [31:0] value;
        logic        last;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CANCEL, ST_QUERY, ST_BKT_RD, ST_BKT_EMIT,
        ST_SCH_PREP, ST_SCH_SCAN, ST_SCH_ENTER,
        ST_HIST_RD, ST_HIST_WR, ST_FIND, ST_FIND_CHK, ST_FIRE,
        ST_RP_DIFF, ST_RP_EMIT, ST_RP_BASE
    } state_t;

    typedef struct packed {
        logic accept;
        logic cancel;
        logic query;
        logic bkt_read;
        logic bkt_emit;
        logic sch_prep;
        logic sch_scan;
        logic sch_enter;
        logic lat_bin;
        logic hist_inc;
        logic find_scan;
        logic fire;
        logic rp_diff;
        logic rp_emit;
        logic rp_base;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic first;
        logic fire_ok;
    } sts_t;

    function automatic logic [3:0] lat_bucket(input logic [15:0] lat);
        logic [3:0] b;
        logic       hit;
        b   = 4'(BUCKETS);
        hit = 1'b0;
        for (int i = 0; i < BUCKETS; i++) begin
            if (!hit && lat <= {6'd0, LAT_EDGE[i]}) begin
                b   = 4'(i);
                hit = 1'b1;
            end
        end
        return b;
    endfunction

endpackage

@@ rtl/core/dctq_ctrl.sv @@
// Sequencer for the timer queue operations.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dctq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         op,
    input  dctq_pkg::sts_t     sts,
    output dctq_pkg::cmd_t     cmd,
    output logic               busy
);
    import dctq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_SCHED:  state_next = ST_SCH_PREP;
                        OP_CANCEL: state_next = ST_CANCEL;
                        OP_TIME:   state_next = ST_HIST_RD;
                        OP_HIST:   state_next = ST_BKT_RD;
                        OP_QUERY:  state_next = ST_QUERY;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CANCEL:    state_next = ST_IDLE;
            ST_QUERY:     state_next = ST_IDLE;
            ST_BKT_RD:    state_next = ST_BKT_EMIT;
            ST_BKT_EMIT:  state_next = ST_IDLE;
            ST_SCH_PREP:  state_next = ST_SCH_SCAN;
            ST_SCH_SCAN:  state_next = sts.scan_last ? ST_SCH_ENTER : ST_SCH_SCAN;
            ST_SCH_ENTER: state_next = sts.first ? ST_RP_DIFF : ST_IDLE;
            ST_HIST_RD:   state_next = ST_HIST_WR;
            ST_HIST_WR:   state_next = ST_FIND;
            ST_FIND:      state_next = sts.scan_last ? ST_FIND_CHK : ST_FIND;
            ST_FIND_CHK:  state_next = sts.fire_ok ? ST_FIRE : ST_RP_DIFF;
            ST_FIRE:      state_next = ST_FIND;
            ST_RP_DIFF:   state_next = ST_RP_EMIT;
            ST_RP_EMIT:   state_next = ST_RP_BASE;
            ST_RP_BASE:   state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = (state_reg == ST_IDLE) && start;
        cmd.cancel    = (state_reg == ST_CANCEL);
        cmd.query     = (state_reg == ST_QUERY);
        cmd.bkt_read  = (state_reg == ST_BKT_RD);
        cmd.bkt_emit  = (state_reg == ST_BKT_EMIT);
        cmd.sch_prep  = (state_reg == ST_SCH_PREP);
        cmd.sch_scan  = (state_reg == ST_SCH_SCAN);
        cmd.sch_enter = (state_reg == ST_SCH_ENTER);
        cmd.lat_bin   = (state_reg == ST_HIST_RD);
        cmd.hist_inc  = (state_reg == ST_HIST_WR);
        cmd.find_scan = (state_reg == ST_FIND);
        cmd.fire      = (state_reg == ST_FIRE);
        cmd.rp_diff   = (state_reg == ST_RP_DIFF);
        cmd.rp_emit   = (state_reg == ST_RP_EMIT);
        cmd.rp_base   = (state_reg == ST_RP_BASE);
        busy          = (state_reg != ST_IDLE);
    end

    `ASSERT_NXT(a_base_then_idle, clk, rst_n, state_reg == ST_RP_BASE, state_reg == ST_IDLE)
    `ASSERT_NXT(a_fire_rescans, clk, rst_n, state_reg == ST_FIRE, state_reg == ST_FIND)
    `ASSERT_IMP(a_busy_blocks, clk, rst_n, busy, !cmd.accept)
endmodule

@@ rtl/core/dctq_dp.sv @@
// Entry store, scan unit, histogram memory and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dctq_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  dctq_pkg::req_t   req,
    input  dctq_pkg::cmd_t   cmd,
    output dctq_pkg::sts_t   sts,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             rsp_valid,
    output dctq_pkg::rsp_t   rsp
);
    import dctq_pkg::*;

    logic [63:0]       dl_mem  [SLOTS];
    logic [31:0]       per_mem [SLOTS];
    logic [31:0]       ord_mem [SLOTS];
    logic [SLOTS-1:0]  pend_reg;
    logic [31:0]       order_cnt_reg;
    logic [63:0]       baseline_reg;
    logic [15:0]       min_reg;
    logic [31:0]       max_reg;
    req_t              req_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic [63:0]       sdl_reg;
    logic              first_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [63:0]       best_dl_reg;
    logic [31:0]       best_per_reg;
    logic [31:0]       best_ord_reg;
    logic [FIRE_W-1:0] fire_cnt_reg;
    logic [63:0]       diff_reg;
    logic              le_reg;
    logic [31:0]       delay_reg;

    logic [31:0]       hist_mem [BUCKETS+1];
    logic [BUCKETS:0]  hist_vld_reg;
    logic [31:0]       hist_rd_reg;
    logic              hist_ok_reg;
    logic [3:0]        hb_reg;

    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [63:0] ent_dl;
    logic [31:0] ent_ord;
    logic [31:0] od;
    logic        better;
    logic        scan_last;
    logic [64:0] nd_sum;
    logic [63:0] nd;
    logic [3:0]  bin;
    logic [3:0]  hrd_addr;
    logic [31:0] delay;

    assign ent_dl    = dl_mem[idx_reg];
    assign ent_ord   = ord_mem[idx_reg];
    assign od        = ent_ord - best_ord_reg;
    assign better    = pend_reg[idx_reg] && (!best_found_reg || ent_dl < best_dl_reg
                       || (ent_dl == best_dl_reg && od != 32'd0 && od[31]));
    assign scan_last = (idx_reg == SLOT_W'(SLOTS - 1));
    assign nd_sum    = {1'b0, best_dl_reg} + {33'd0, best_per_reg};
    assign nd        = nd_sum[64] ? {64{1'b1}} : nd_sum[63:0];
    assign bin       = lat_bucket(req_reg.now[15:0] - baseline_reg[15:0]);
    assign hrd_addr  = cmd.lat_bin ? bin :
                       ((req_reg.bucket > 4'(BUCKETS)) ? 4'd0 : req_reg.bucket);

    always_comb
    begin
        if (!best_found_reg)
            delay = max_reg;
        else if (le_reg || diff_reg <= {48'd0, min_reg})
            delay = {16'd0, min_reg};
        else if (diff_reg < {32'd0, max_reg})
            delay = diff_reg[31:0];
        else
            delay = max_reg;
    end

    assign sts.scan_last = scan_last;
    assign sts.first     = first_reg;
    assign sts.fire_ok   = best_found_reg && (best_dl_reg <= req_reg.now)
                           && (fire_cnt_reg != FIRE_W'(FIRE_LIMIT));

    always_comb
    begin
        rsp_next = '0;
        if (cmd.query)
        begin
            rsp_next.kind       = KIND_SLOT;
            rsp_next.fired_slot = req_reg.slot;
            rsp_next.value      = {31'd0, pend_reg[req_reg.slot]};
            rsp_next.last       = 1'b1;
        end
        if (cmd.bkt_emit)
        begin
            rsp_next.kind  = KIND_HIST;
            rsp_next.value = hist_ok_reg ? hist_rd_reg : 32'd0;
            rsp_next.last  = 1'b1;
        end
        if (cmd.fire)
        begin
            rsp_next.kind       = KIND_FIRED;
            rsp_next.fired_slot = best_idx_reg;
        end
        if (cmd.rp_emit)
        begin
            rsp_next.kind  = KIND_DELAY;
            rsp_next.value = delay;
            rsp_next.last  = 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            req_reg <= req;
        if (cmd.sch_prep)
        begin
            per_mem[req_reg.slot] <= req_reg.period;
            sdl_reg <= req_reg.relative ? req_reg.now + req_reg.time_value
                                        : req_reg.time_value;
        end
        if (cmd.sch_enter)
        begin
            dl_mem[req_reg.slot]  <= sdl_reg;
            ord_mem[req_reg.slot] <= order_cnt_reg;
            best_dl_reg           <= sdl_reg;
        end
        if (cmd.find_scan && better)
        begin
            best_idx_reg <= idx_reg;
            best_dl_reg  <= ent_dl;
            best_per_reg <= per_mem[idx_reg];
            best_ord_reg <= ent_ord;
        end
        if (cmd.fire && best_per_reg != 32'd0)
        begin
            dl_mem[best_idx_reg]  <= nd;
            ord_mem[best_idx_reg] <= order_cnt_reg;
        end
        if (cmd.rp_diff)
        begin
            diff_reg <= best_dl_reg - req_reg.now;
            le_reg   <= best_dl_reg <= req_reg.now;
        end
        if (cmd.rp_emit)
            delay_reg <= delay;
        if (cmd.lat_bin)
            hb_reg <= bin;
        if (cmd.lat_bin || cmd.bkt_read)
            hist_rd_reg <= hist_mem[hrd_addr];
        if (cmd.hist_inc)
            hist_mem[hb_reg] <= hist_ok_reg ? hist_rd_reg + 32'd1 : 32'd1;
        rsp_reg <= rsp_next;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            order_cnt_reg  <= '0;
            baseline_reg   <= '0;
            min_reg        <= MIN_RESET;
            max_reg        <= MAX_RESET;
            idx_reg        <= '0;
            first_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            hist_vld_reg   <= '0;
            hist_ok_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= cmd.query || cmd.bkt_emit || cmd.fire || cmd.rp_emit;
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN)
                    min_reg <= cfg_data[15:0];
                else
                    max_reg <= cfg_data;
            end
            if (cmd.cancel)
                pend_reg[req_reg.slot] <= 1'b0;
            if (cmd.sch_prep)
            begin
                pend_reg[req_reg.slot] <= 1'b0;
                first_reg <= 1'b1;
                idx_reg   <= '0;
            end
            if (cmd.sch_scan)
            begin
                if (pend_reg[idx_reg] && !(sdl_reg < ent_dl))
                    first_reg <= 1'b0;
                idx_reg <= scan_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.sch_enter)
            begin
                pend_reg[req_reg.slot] <= 1'b1;
                order_cnt_reg  <= order_cnt_reg + 32'd1;
                best_found_reg <= 1'b1;
            end
            if (cmd.lat_bin || cmd.bkt_read)
                hist_ok_reg <= hist_vld_reg[hrd_addr]
                               && (cmd.lat_bin || req_reg.bucket <= 4'(BUCKETS));
            if (cmd.hist_inc)
            begin
                hist_vld_reg[hb_reg] <= 1'b1;
                fire_cnt_reg   <= '0;
                best_found_reg <= 1'b0;
                idx_reg        <= '0;
            end
            if (cmd.find_scan)
            begin
                if (better)
                    best_found_reg <= 1'b1;
                idx_reg <= scan_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.fire)
            begin
                fire_cnt_reg   <= fire_cnt_reg + 1'b1;
                best_found_reg <= 1'b0;
                if (best_per_reg != 32'd0)
                    order_cnt_reg <= order_cnt_reg + 32'd1;
                else
                    pend_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.rp_base)
                baseline_reg <= req_reg.now + {32'd0, delay_reg};
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_IMP(a_fire_pending, clk, rst_n, cmd.fire, pend_reg[best_idx_reg] && best_found_reg)
    `ASSERT_IMP(a_fired_not_last, clk, rst_n, rsp_valid && rsp.kind == KIND_FIRED, !rsp.last)
    `ASSERT_IMP(a_fire_limit, clk, rst_n, cmd.fire, fire_cnt_reg != FIRE_W'(FIRE_LIMIT))
endmodule

@@ rtl/core/deadline_callout_timer_queue.sv @@
// Top level of the deadline callout timer queue.
// channel | signals                          | beat taken when
// input   | start, busy, req                 | start && !busy
// result  | rsp_valid, rsp                   | rsp_valid (one cycle, no stall)
// config  | cfg_we, cfg_index, cfg_data      | cfg_we
// A schedule scans all 16 entries and ends in a delay report when the entry becomes
// the head. A time event bins its latency, fires due heads and reports the next delay:
// each head search walks all 16 entries through the single entry read port.
// Reset clears pending flags and histogram valid bits, and presets min and max delay.
// Results leave from a register in the cycle after they are formed.
`timescale 1ns / 1ps
module deadline_callout_timer_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dctq_pkg::req_t   req,
    output logic             rsp_valid,
    output dctq_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);
    import dctq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dctq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dctq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );
endmodule
